>>> rtl/core/r2c_pkg.sv
package r2c_pkg;

  localparam int CH_W    = 8;
  localparam int FRAC_W  = 16;
  localparam int OUT_W   = FRAC_W + 1;
  localparam int RECIP_W = 2 * CH_W + 9;
  localparam int PROD_W  = CH_W + RECIP_W;
  localparam int QD_W    = OUT_W + CH_W;
  localparam int REM_W   = CH_W + 1;
  localparam int TAB_N   = 1 << CH_W;

  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};
  localparam logic [OUT_W-1:0] FRAC_ONE = OUT_W'(1) << FRAC_W;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } r2c_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] cyan;
    logic [OUT_W-1:0] magenta;
    logic [OUT_W-1:0] yellow;
    logic [OUT_W-1:0] black;
  } r2c_out_t;

  typedef struct packed {
    logic               valid;
    logic [CH_W-1:0]    mx;
    logic [CH_W-1:0]    num_c;
    logic [CH_W-1:0]    num_m;
    logic [CH_W-1:0]    num_y;
    logic [RECIP_W-1:0] recip;
    logic [OUT_W-1:0]   black;
  } r2c_front_t;

  typedef logic [RECIP_W-1:0] recip_tab_t [TAB_N];

  // floor(2^(RECIP_W-1) / den) by shift-subtract, den 0 gives 0
  function automatic recip_tab_t build_recip();
    recip_tab_t         tab;
    logic [RECIP_W-1:0] dividend;
    logic [RECIP_W-1:0] quo;
    logic [CH_W:0]      rem;
    logic [CH_W:0]      den;
    int                 d;
    int                 i;
    dividend = RECIP_W'(1) << (RECIP_W - 1);
    for (d = 0; d < TAB_N; d++) begin
      den = (CH_W+1)'(d);
      quo = '0;
      rem = '0;
      if (d != 0) begin
        for (i = RECIP_W - 1; i >= 0; i--) begin
          rem = {rem[CH_W-1:0], dividend[i]};
          if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
          end
        end
      end
      tab[d] = quo;
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

>>> rtl/core/rgb_to_cmyk_converter_top.sv
// channel  ports                      handshake
// input    start, busy, in_data       word taken when start high and busy low
// result   out_valid, out_data        word shown for one cycle, no backpressure
//
// one pixel per clock, busy is never raised
// registered steps: max/numerators, reciprocal table, estimate multiply,
// back multiply, remainder correction and rounding
// rst_n synchronous, clears the valid bits only
// results cannot be stalled, so the pipeline never holds
module rgb_to_cmyk_converter_top
  import r2c_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  r2c_in_t  in_data,
  output logic     out_valid,
  output r2c_out_t out_data
);

  r2c_front_t       fr;
  logic [2:0]       lane_v;
  logic [OUT_W-1:0] cyan;
  logic [OUT_W-1:0] magenta;
  logic [OUT_W-1:0] yellow;
  logic [OUT_W-1:0] blk0_r;
  logic [OUT_W-1:0] blk1_r;
  logic [OUT_W-1:0] blk2_r;

  assign busy = 1'b0;

  r2c_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (start && !busy),
    .pix   (in_data),
    .fr    (fr)
  );

  r2c_div u_div_c (
    .clk   (clk),
    .rst_n (rst_n),
    .in_v  (fr.valid),
    .num   (fr.num_c),
    .den   (fr.mx),
    .recip (fr.recip),
    .out_v (lane_v[0]),
    .quo   (cyan)
  );

  r2c_div u_div_m (
    .clk   (clk),
    .rst_n (rst_n),
    .in_v  (fr.valid),
    .num   (fr.num_m),
    .den   (fr.mx),
    .recip (fr.recip),
    .out_v (lane_v[1]),
    .quo   (magenta)
  );

  r2c_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .in_v  (fr.valid),
    .num   (fr.num_y),
    .den   (fr.mx),
    .recip (fr.recip),
    .out_v (lane_v[2]),
    .quo   (yellow)
  );

  // black waits for the divider lanes
  always_ff @(posedge clk) begin
    blk0_r <= fr.black;
    blk1_r <= blk0_r;
    blk2_r <= blk1_r;
  end

  assign out_valid        = &lane_v;
  assign out_data.cyan    = cyan;
  assign out_data.magenta = magenta;
  assign out_data.yellow  = yellow;
  assign out_data.black   = blk2_r;

endmodule

>>> rtl/core/r2c_front.sv
module r2c_front
  import r2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  r2c_in_t    pix,
  output r2c_front_t fr
);

  logic            v1_r;
  logic [CH_W-1:0] mx1_r;
  logic [CH_W-1:0] nc1_r;
  logic [CH_W-1:0] nm1_r;
  logic [CH_W-1:0] ny1_r;
  logic [CH_W-1:0] mx_nxt;
  logic [CH_W-1:0] mx_rg;
  logic [CH_W-1:0] kn;
  logic [OUT_W-1:0] black_nxt;

  r2c_front_t fr_r;

  // stage 1: largest channel and ink numerators
  always_comb begin
    mx_rg  = (pix.green > pix.red) ? pix.green : pix.red;
    mx_nxt = (pix.blue > mx_rg) ? pix.blue : mx_rg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    mx1_r <= mx_nxt;
    nc1_r <= mx_nxt - pix.red;
    nm1_r <= mx_nxt - pix.green;
    ny1_r <= mx_nxt - pix.blue;
  end

  // stage 2: reciprocal lookup and black, n*65536/255 = n*257 + n/255
  always_comb begin
    kn        = CH_MAX - mx1_r;
    black_nxt = OUT_W'(kn) * OUT_W'(257) + OUT_W'(kn[CH_W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r.valid <= 1'b0;
    end else begin
      fr_r.valid <= v1_r;
    end
    fr_r.mx    <= mx1_r;
    fr_r.num_c <= nc1_r;
    fr_r.num_m <= nm1_r;
    fr_r.num_y <= ny1_r;
    fr_r.recip <= RECIP_TAB[mx1_r];
    fr_r.black <= black_nxt;
  end

  assign fr = fr_r;

endmodule

>>> rtl/core/r2c_div.sv
module r2c_div
  import r2c_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  logic [CH_W-1:0]    num,
  input  logic [CH_W-1:0]    den,
  input  logic [RECIP_W-1:0] recip,
  output logic               out_v,
  output logic [OUT_W-1:0]   quo
);

  logic [2:0]         v_r;
  logic [PROD_W-1:0]  prod;
  logic [OUT_W-1:0]   q0_r;
  logic [CH_W-1:0]    num1_r;
  logic [CH_W-1:0]    den1_r;
  logic [OUT_W-1:0]   q0b_r;
  logic [QD_W-1:0]    qd_r;
  logic [CH_W-1:0]    num2_r;
  logic [CH_W-1:0]    den2_r;
  logic [QD_W-1:0]    diff;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem2;
  logic               c1;
  logic               c2;
  logic [OUT_W-1:0]   quo_nxt;
  logic [OUT_W-1:0]   quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  // estimate, low by at most one
  assign prod = PROD_W'(num) * PROD_W'(recip);

  always_ff @(posedge clk) begin
    q0_r   <= prod[CH_W +: OUT_W];
    num1_r <= num;
    den1_r <= den;
  end

  always_ff @(posedge clk) begin
    qd_r   <= QD_W'(q0_r) * QD_W'(den1_r);
    q0b_r  <= q0_r;
    num2_r <= num1_r;
    den2_r <= den1_r;
  end

  // remainder correction, then round half up
  always_comb begin
    diff    = QD_W'({num2_r, FRAC_W'(0)}) - qd_r;
    rem     = diff[REM_W-1:0];
    c1      = rem >= {1'b0, den2_r};
    rem2    = c1 ? (rem - {1'b0, den2_r}) : rem;
    c2      = {rem2, 1'b0} >= (REM_W+1)'(den2_r);
    quo_nxt = q0b_r + OUT_W'(c1) + OUT_W'(c2);
    if (den2_r == '0) begin
      quo_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign out_v = v_r[2];
  assign quo   = quo_r;

endmodule

>>> rtl/core/r2c_checker.sv
module r2c_checker
  import r2c_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input r2c_out_t out_data
);

  // every result comes from an accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 5))
    else $error("result without an accepted word");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted word gave no result");

  // the largest channel always has zero ink
  a_one_ink_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cyan == '0 || out_data.magenta == '0 ||
                   out_data.yellow == '0))
    else $error("no ink is zero");

  // pure black gives no colour ink
  a_pure_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.black == FRAC_ONE) |->
      (out_data.cyan == '0 && out_data.magenta == '0 && out_data.yellow == '0))
    else $error("pure black with colour ink");

endmodule

bind rgb_to_cmyk_converter_top r2c_checker u_r2c_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import r2c_pkg::*;
();

  localparam int DIR_N   = 20;
  localparam int RAND_N  = 1130;
  localparam int PHASE_N = 3;

  typedef struct packed {
    r2c_in_t  px;
    logic     typed;
    r2c_out_t cmyk;
  } dir_row_t;

  // directed pixels, expected inks typed in only where obvious
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{'{8'd0,   8'd0,   8'd0},   1'b1, '{'0, '0, '0, FRAC_ONE}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{'0, '0, '0, '0}},
    '{'{8'd255, 8'd0,   8'd0},   1'b1, '{'0, FRAC_ONE, FRAC_ONE, '0}},
    '{'{8'd0,   8'd255, 8'd0},   1'b1, '{FRAC_ONE, '0, FRAC_ONE, '0}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{FRAC_ONE, FRAC_ONE, '0, '0}},
    '{'{8'd255, 8'd255, 8'd0},   1'b1, '{'0, '0, FRAC_ONE, '0}},
    '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{FRAC_ONE, '0, '0, '0}},
    '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{'0, FRAC_ONE, '0, '0}},
    '{'{8'd1,   8'd1,   8'd1},   1'b0, '{'0, '0, '0, '0}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b0, '{'0, '0, '0, '0}},
    '{'{8'd254, 8'd254, 8'd254}, 1'b0, '{'0, '0, '0, '0}},
    '{'{8'd1,   8'd0,   8'd0},   1'b0, '{'0, '0, '0, '0}},
    '{'{8'd0,   8'd0,   8'd1},   1'b0, '{'0, '0, '0, '0}},
    '{'{8'd255, 8'd254, 8'd1},   1'b0, '{'0, '0, '0, '0}},
    '{'{8'd2,   8'd1,   8'd0},   1'b0, '{'0, '0, '0, '0}},
    '{'{8'd3,   8'd2,   8'd1},   1'b0, '{'0, '0, '0, '0}},
    '{'{8'd170, 8'd85,  8'd255}, 1'b0, '{'0, '0, '0, '0}},
    '{'{8'd85,  8'd170, 8'd0},   1'b0, '{'0, '0, '0, '0}},
    '{'{8'd127, 8'd128, 8'd129}, 1'b0, '{'0, '0, '0, '0}},
    '{'{8'd200, 8'd100, 8'd50},  1'b0, '{'0, '0, '0, '0}}
  };

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  r2c_in_t  in_data;
  logic     out_valid;
  r2c_out_t out_data;

  r2c_out_t cmyk_due [$];
  int       n_sent;
  int       n_checked;
  int       n_bad;

  rgb_to_cmyk_converter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("timeout with %0d words outstanding", cmyk_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // num / den in UQ1.16, halves rounded up
  function automatic logic [OUT_W-1:0] uq16_ratio(input int unsigned num,
                                                 input int unsigned den);
    longint unsigned n;
    longint unsigned d;
    n = longint'(num) * 131072 + den;
    d = longint'(den) * 2;
    return OUT_W'(n / d);
  endfunction

  function automatic r2c_out_t cmyk_of(input r2c_in_t px);
    r2c_out_t    res;
    int unsigned mx;
    mx = px.red;
    if (px.green > mx) mx = px.green;
    if (px.blue > mx) mx = px.blue;
    res = '0;
    if (mx != 0) begin
      res.cyan    = uq16_ratio(mx - px.red, mx);
      res.magenta = uq16_ratio(mx - px.green, mx);
      res.yellow  = uq16_ratio(mx - px.blue, mx);
    end
    res.black = uq16_ratio(CH_MAX - mx, CH_MAX);
    return res;
  endfunction

  function automatic r2c_in_t random_pixel();
    r2c_in_t px;
    int      v;
    px = r2c_in_t'($urandom);
    case ($urandom_range(9))
      0: begin
        v = $urandom_range(255);
        px = '{CH_W'(v), CH_W'(v), CH_W'(v)};
      end
      1: begin
        px.red   = ($urandom_range(2) == 0) ? 8'd0 : ($urandom_range(1) ? 8'd255 : px.red);
        px.green = ($urandom_range(2) == 0) ? 8'd0 : ($urandom_range(1) ? 8'd255 : px.green);
        px.blue  = ($urandom_range(2) == 0) ? 8'd0 : ($urandom_range(1) ? 8'd255 : px.blue);
      end
      2: px = '{CH_W'($urandom_range(3)), CH_W'($urandom_range(3)),
                CH_W'($urandom_range(3))};
      3: begin
        v = $urandom_range(254, 1);
        px = '{CH_W'(v + $urandom_range(2) - 1), CH_W'(v + $urandom_range(2) - 1),
               CH_W'(v)};
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic idle_cycle();
    start   <= 1'b0;
    in_data <= r2c_in_t'($urandom);
    @(posedge clk);
  endtask

  task automatic push_pixel(input r2c_in_t px, input r2c_out_t cmyk);
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    cmyk_due.push_back(cmyk);
    n_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (cmyk_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    r2c_out_t want;
    if (rst_n && out_valid) begin
      if (cmyk_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected word: c=%0d m=%0d y=%0d k=%0d", out_data.cyan,
                   out_data.magenta, out_data.yellow, out_data.black);
      end else begin
        want = cmyk_due.pop_front();
        n_checked++;
        if (out_data.cyan !== want.cyan || out_data.magenta !== want.magenta ||
            out_data.yellow !== want.yellow || out_data.black !== want.black) begin
          n_bad++;
          if (n_bad <= 10)
            $display("word %0d: expected c=%0d m=%0d y=%0d k=%0d, got c=%0d m=%0d y=%0d k=%0d",
                     n_checked, want.cyan, want.magenta, want.yellow, want.black,
                     out_data.cyan, out_data.magenta, out_data.yellow, out_data.black);
        end
      end
    end
  end

  initial begin
    int      idle_pct [PHASE_N];
    int      phase;
    int      i;
    int      guard;
    r2c_in_t px;
    idle_pct  = '{0, 51, 10};
    n_sent    = 0;
    n_checked = 0;
    n_bad     = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_N; i++) begin
      px = DIR_ROWS[i].px;
      push_pixel(px, DIR_ROWS[i].typed ? DIR_ROWS[i].cmyk : cmyk_of(px));
    end
    drain();

    for (phase = 0; phase < PHASE_N; phase++) begin
      for (i = 0; i < RAND_N / PHASE_N; i++) begin
        while ($urandom_range(99) < idle_pct[phase]) idle_cycle();
        px = random_pixel();
        push_pixel(px, cmyk_of(px));
      end
      drain();
    end

    start <= 1'b0;
    for (guard = 0; guard < 100 && cmyk_due.size() != 0; guard++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (cmyk_due.size() != 0) begin
      $display("%0d expected words never arrived", cmyk_due.size());
      n_bad += cmyk_due.size();
    end
    $display("%0d pixels sent (%0d directed), random part in three idle phases",
             n_sent, DIR_N);
    $display("%0d words checked, %0d mismatches", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
